>>> sv/dsil_pkg.sv
`timescale 1ns / 1ps
package dsil_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int KEY_W          = 16;
    localparam int ID_W           = 16;
    localparam int POS_OUT_W      = 5;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // one list entry; key is compared as signed
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

endpackage

>>> sv/dsil_cell.sv
`timescale 1ns / 1ps
module dsil_cell
    import dsil_pkg::*;
#(
    parameter bit ASCEND = 1'b1
)
(
    input  logic   clk,
    input  entry_t new_entry,   // entry being inserted
    input  entry_t left_entry,  // entry of the cell one place lower
    input  logic   left_hit,    // lower cell also hits: shift from it
    input  logic   occupied,
    input  logic   insert,
    output logic   hit,
    output entry_t entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   cmp;

    // ascending: new <= stored; descending: stored <= new (ties insert in front)
    assign cmp = ASCEND ? ($signed(new_entry.key) <= $signed(entry_reg.key))
                        : ($signed(entry_reg.key) <= $signed(new_entry.key));
    assign hit = !occupied || cmp;

    always_comb
    begin
        entry_next = entry_reg;
        if (insert && hit)
        begin
            entry_next = left_hit ? left_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> sv/dsil_list.sv
`timescale 1ns / 1ps
module dsil_list
    import dsil_pkg::*;
#(
    parameter int DEPTH  = LIST_DEPTH_DEF,
    parameter bit ASCEND = 1'b1
)
(
    input  logic                       clk,
    input  entry_t                     new_entry,
    input  logic [$clog2(DEPTH+1)-1:0] count,
    input  logic                       insert,
    output logic [$clog2(DEPTH)-1:0]   pos
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = $clog2(DEPTH);

    logic   [DEPTH-1:0] hit;
    logic   [DEPTH-1:0] first;
    entry_t             entries [DEPTH];

    // hit is a thermometer over the row: empty cells always hit
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        logic   left_h;
        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_h = 1'b0;
        end
        else
        begin : g_body
            assign left_e = entries[i-1];
            assign left_h = hit[i-1];
        end

        dsil_cell #(
            .ASCEND (ASCEND)
        ) u_cell (
            .clk        (clk),
            .new_entry  (new_entry),
            .left_entry (left_e),
            .left_hit   (left_h),
            .occupied   (CNT_W'(i) < count),
            .insert     (insert),
            .hit        (hit[i]),
            .entry      (entries[i])
        );

        assign first[i] = left_h ? 1'b0 : hit[i];
    end

    // one-hot rising edge of the thermometer -> index
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                pos = pos | POS_W'(i);
            end
        end
    end

endmodule

>>> sv/dual_sorted_insert_lists.sv
`timescale 1ns / 1ps
// Two bounded sorted lists updated together, one request per clock. Each
// request with entity_present set inserts (tick_key, entity_id) into an
// ascending tick list and (render_key, sprite_id) into a descending render
// list; a new entry lands in front of existing entries with an equal key.
// The result carries the landing index in each list (low 5 bits) and a status:
// inserted, skipped (no entity, nothing changes) or full (either list already
// holds LIST_DEPTH entries, nothing changes, positions zero). Each list is a
// row of LIST_DEPTH cells that all compare the new key in parallel and shift
// by one place in the same cycle, so a request is accepted every cycle and
// its result appears in the output register in the following cycle; the only
// stall is m_tready held low. Stored entries are not readable from the ports.
module dual_sorted_insert_lists
    import dsil_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entity_id, tick_key, sprite_id, render_key
    input  logic [0:0]  s_tuser,   // entity_present

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // tick_position, render_position, zero pad
    output logic [1:0]  m_tuser    // status
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int POS_W = $clog2(LIST_DEPTH);

    // both lists always grow together, so one fill count serves both
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             valid_reg;
    logic             valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic [POS_OUT_W-1:0] tpos_reg;
    logic [POS_OUT_W-1:0] tpos_next;
    logic [POS_OUT_W-1:0] rpos_reg;
    logic [POS_OUT_W-1:0] rpos_next;

    logic   s_fire;
    logic   is_full;
    logic   insert;
    entry_t tick_entry;
    entry_t render_entry;
    logic [POS_W-1:0] tick_pos;
    logic [POS_W-1:0] render_pos;
    logic [POS_W+POS_OUT_W-1:0] tick_pos_ext;
    logic [POS_W+POS_OUT_W-1:0] render_pos_ext;

    assign s_tready = !valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(LIST_DEPTH));
    assign insert   = s_fire && s_tuser[0] && !is_full;

    assign tick_entry.key   = s_tdata[31:16];
    assign tick_entry.id    = s_tdata[15:0];
    assign render_entry.key = s_tdata[63:48];
    assign render_entry.id  = s_tdata[47:32];

    dsil_list #(
        .DEPTH  (LIST_DEPTH),
        .ASCEND (1'b1)
    ) u_tick (
        .clk       (clk),
        .new_entry (tick_entry),
        .count     (count_reg),
        .insert    (insert),
        .pos       (tick_pos)
    );

    dsil_list #(
        .DEPTH  (LIST_DEPTH),
        .ASCEND (1'b0)
    ) u_render (
        .clk       (clk),
        .new_entry (render_entry),
        .count     (count_reg),
        .insert    (insert),
        .pos       (render_pos)
    );

    // positions reported modulo 32
    assign tick_pos_ext   = {{POS_OUT_W{1'b0}}, tick_pos};
    assign render_pos_ext = {{POS_OUT_W{1'b0}}, render_pos};

    always_comb
    begin
        count_next  = count_reg;
        valid_next  = valid_reg;
        status_next = status_reg;
        tpos_next   = tpos_reg;
        rpos_next   = rpos_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (s_fire)
        begin
            valid_next = 1'b1;
            tpos_next  = '0;
            rpos_next  = '0;
            if (!s_tuser[0])
            begin
                status_next = ST_SKIPPED;
            end
            else if (is_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                tpos_next   = tick_pos_ext[POS_OUT_W-1:0];
                rpos_next   = render_pos_ext[POS_OUT_W-1:0];
                count_next  = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        tpos_reg   <= tpos_next;
        rpos_reg   <= rpos_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(16 - 2*POS_OUT_W){1'b0}}, rpos_reg, tpos_reg};

    // fill count never passes the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("fill count beyond list depth");

    // every accepted request leaves a result in the output register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_tvalid)
        else $error("accepted request produced no result");

    // skipped or full requests leave the fill count untouched
    a_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !insert) |=> $stable(count_reg))
        else $error("list changed on a skipped or full request");

    // a non-insert result reports zero positions
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_INSERTED) |-> (m_tdata == '0))
        else $error("nonzero position on skipped or full result");

endmodule

>>> bench/tb_dual_sorted_insert_lists.sv
`timescale 1ns / 1ps
module tb_dual_sorted_insert_lists;
    import dsil_pkg::*;

    localparam int RANDOM_REQUESTS = 690;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;

    // one stored list entry; key compared as signed
    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
    } list_entry_s;

    // what one request should produce
    typedef struct {
        status_t              status;
        logic [POS_OUT_W-1:0] tick_pos;
        logic [POS_OUT_W-1:0] render_pos;
    } landing_s;

    // Shadow of both sorted lists plus the queue of landing positions
    // still owed by the block.
    class dual_list_predictor;
        list_entry_s tick_list[$];
        list_entry_s render_list[$];
        landing_s    owed_landings[$];
        int unsigned mismatch_count;
        int unsigned inserted_seen;
        int unsigned skipped_seen;
        int unsigned full_seen;

        function void note_request(bit present, logic [ID_W-1:0] eid,
                                   logic signed [KEY_W-1:0] tkey,
                                   logic [ID_W-1:0] sid,
                                   logic signed [KEY_W-1:0] rkey);
            landing_s    land;
            int unsigned tp;
            int unsigned rp;
            land.status     = ST_SKIPPED;
            land.tick_pos   = '0;
            land.render_pos = '0;
            if (present)
            begin
                if (tick_list.size() >= LIST_DEPTH_DEF || render_list.size() >= LIST_DEPTH_DEF)
                begin
                    land.status = ST_FULL;
                end
                else
                begin
                    // ascending: in front of the first key >= new key
                    tp = tick_list.size();
                    for (int i = 0; i < tick_list.size(); i++)
                    begin
                        if (tkey <= tick_list[i].key)
                        begin
                            tp = i;
                            break;
                        end
                    end
                    // descending: in front of the first key <= new key
                    rp = render_list.size();
                    for (int i = 0; i < render_list.size(); i++)
                    begin
                        if (render_list[i].key <= rkey)
                        begin
                            rp = i;
                            break;
                        end
                    end
                    tick_list.insert(tp, '{key: tkey, id: eid});
                    render_list.insert(rp, '{key: rkey, id: sid});
                    land.status     = ST_INSERTED;
                    land.tick_pos   = tp[POS_OUT_W-1:0];
                    land.render_pos = rp[POS_OUT_W-1:0];
                end
            end
            owed_landings.push_back(land);
        endfunction

        function void check_result(logic [1:0] st, logic [POS_OUT_W-1:0] tp,
                                   logic [POS_OUT_W-1:0] rp);
            landing_s want;
            if (st == ST_INSERTED)
                inserted_seen++;
            else if (st == ST_SKIPPED)
                skipped_seen++;
            else
                full_seen++;
            if (owed_landings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d tick %0d render %0d", st, tp, rp);
                return;
            end
            want = owed_landings.pop_front();
            if (st !== want.status || tp !== want.tick_pos || rp !== want.render_pos)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected status %0d tick %0d render %0d, got %0d %0d %0d",
                             want.status, want.tick_pos, want.render_pos, st, tp, rp);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // entity_id, tick_key, sprite_id, render_key
    logic [0:0]  s_tuser;   // entity_present
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // tick_position, render_position, zero pad
    logic [1:0]  m_tuser;   // status

    dual_list_predictor lists = new();

    // shared between the request driver and the result sink
    bit          calm;          // no idling on either side
    bit          holdoff_req;   // sink: start a long stall
    int unsigned hold_left;     // cycles of stall still to go
    int unsigned cycle_count;
    int unsigned requests_sent;

    dual_sorted_insert_lists dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Monitor: both handshakes are sampled right after the edge, where every
    // signal still shows its value from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                lists.note_request(s_tuser[0], s_tdata[15:0], s_tdata[31:16],
                                   s_tdata[47:32], s_tdata[63:48]);
            if (m_tvalid && m_tready)
                lists.check_result(m_tuser, m_tdata[4:0], m_tdata[9:5]);
        end
    end

    // Result sink: random stalls, a calm stretch, and one long hold-off
    // counted here so the block fills up and pushes back on requests.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                hold_left   = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm || !rst_n)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 17);
        end
    end

    // Offer one request and hold it until the block takes it.
    task automatic offer_request(bit present, logic [15:0] eid, logic [15:0] tkey,
                                 logic [15:0] sid, logic [15:0] rkey);
        s_tvalid <= 1'b1;
        s_tuser  <= present;
        s_tdata  <= {rkey, sid, tkey, eid};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        requests_sent++;
    endtask

    // Random gap between requests, skipped while calm or during the hold-off.
    task automatic request_gap();
        if (!calm && hold_left == 0 && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Key mix: clustered small values force ties, some extremes, rest random.
    function automatic logic [15:0] pick_key();
        int          sel;
        int          k;
        sel = $urandom_range(9);
        if (sel < 4)
        begin
            k = int'($urandom_range(6)) - 3;
            return k[15:0];
        end
        else if (sel == 4)
        begin
            case ($urandom_range(2))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom);
    endfunction

    initial
    begin
        bit          present;
        logic [15:0] eid;
        logic [15:0] sid;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        calm          = 1'b0;
        holdoff_req   = 1'b0;
        hold_left     = 0;
        requests_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: skips with all-ones and all-zero fields, extremes of both
        // keys, ties at the front and at the end, and appends past the end.
        offer_request(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_request(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        offer_request(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        offer_request(1'b1, 16'h0001, 16'h0000, 16'h0001, 16'h0000);  // ties go in front
        offer_request(1'b1, 16'h0002, 16'h7FFF, 16'h0002, 16'h8000);  // append at end
        offer_request(1'b1, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF);  // new head
        offer_request(1'b0, 16'hA5A5, 16'h8000, 16'h5A5A, 16'h7FFF);
        offer_request(1'b1, 16'h1234, 16'd100, 16'h4321, -16'sd100);  // middle
        offer_request(1'b1, 16'h0003, 16'h7FFF, 16'h0003, 16'h8000);  // tie at the tail
        offer_request(1'b1, 16'h0004, 16'h8000, 16'h0004, 16'h7FFF);  // tie at the head
        offer_request(1'b1, 16'h8000, 16'hFFFF, 16'h8000, 16'h0001);
        offer_request(1'b1, 16'h7FFF, 16'h0001, 16'h7FFF, 16'hFFFF);

        // Random requests; lists fill up early and every later entity
        // request must come back as full.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 8)
                holdoff_req = 1'b1;
            if (n == 120)
            begin
                // let everything drain before going on; one edge first so
                // the monitor has noted the last accepted request
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (lists.owed_landings.size() != 0)
                    @(posedge clk);
            end
            calm = (n >= 250 && n < 350);
            request_gap();
            present = ($urandom_range(99) < 85);
            eid     = 16'($urandom);
            sid     = 16'($urandom);
            offer_request(present, eid, pick_key(), sid, pick_key());
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        @(posedge clk);
        while (lists.owed_landings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d skipped, %0d refused with a full list",
                 requests_sent, lists.inserted_seen, lists.skipped_seen, lists.full_seen);
        $display("covered key ties, extreme keys, fill to capacity and output back-pressure");
        if (lists.mismatch_count == 0 && lists.owed_landings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
